FILE: hw/rtl/lhcb_pkg.sv
// Shared constants and request/response types for the letter Huffman code builder.
package lhcb_pkg;

   localparam int LETTERS     = 26;
   localparam int COUNT_BITS  = 24;
   localparam int NODES       = 2 * LETTERS - 1;
   localparam int LETTER_BITS = $clog2(LETTERS);
   localparam int NODE_BITS   = $clog2(NODES);
   localparam int WEIGHT_BITS = COUNT_BITS + $clog2(LETTERS) + 1;
   localparam int CODE_BITS   = 25;
   localparam int LEN_BITS    = 5;
   localparam int ENTRY_BITS  = LEN_BITS + CODE_BITS;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]  letter_index;
      logic [23:0] letter_count;
      logic [4:0]  code_length;
      logic [24:0] code_bits;
      logic        last_letter;
   } rsp_type;

endpackage

FILE: hw/rtl/letter_huffman_code_builder.sv
// Letter Huffman code builder: letter counter, tree builder and code emitter.
//
// Usage: text bytes arrive on the req_ channel (req_valid / req_stall /
// req_payload), one per cycle while the block is idle. Letters A-Z and a-z
// are counted without regard to case; other bytes are dropped. Counts
// saturate at 2^24-1. A request with end_of_text set is counted, then the
// block builds a Huffman tree over all 26 letters and returns 26 responses on
// the rsp_ channel, letter A first, last_letter set on Z. Counts then clear.
// The build runs one shared compare/add unit over the node memory: it loads
// the leaves, then for each merge k (k = 26..50) scans nodes below k for the
// two lightest unused ones and writes their sum to node k, then hands codes
// down from the root through each inner node. Responses follow letter by
// letter. req_stall stays high during build and emission.
// A stall on rsp_ holds the response register and pauses the emitter; the
// last response may wait while new text is already being counted.
// Reset (synchronous, active high) clears all counts and control state.
module letter_huffman_code_builder
   import lhcb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INIT      = 4'd1;
   localparam logic [3:0] ST_SCAN      = 4'd2;
   localparam logic [3:0] ST_MERGE     = 4'd3;
   localparam logic [3:0] ST_CODE_INIT = 4'd4;
   localparam logic [3:0] ST_CODE_RD   = 4'd5;
   localparam logic [3:0] ST_CODE_L    = 4'd6;
   localparam logic [3:0] ST_CODE_R    = 4'd7;
   localparam logic [3:0] ST_EMIT_RD   = 4'd8;
   localparam logic [3:0] ST_EMIT_WR   = 4'd9;

   localparam logic [NODE_BITS-1:0]   LAST_LEAF = NODE_BITS'(LETTERS - 1);
   localparam logic [NODE_BITS-1:0]   ROOT      = NODE_BITS'(NODES - 1);
   localparam logic [NODE_BITS-1:0]   FIRST_IN  = NODE_BITS'(LETTERS);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [3:0]           state_ff, state_in;
   logic [NODE_BITS-1:0] idx_ff, idx_in;
   logic [NODE_BITS-1:0] k_ff, k_in;

   // letter counts and tree bookkeeping in flops
   logic [COUNT_BITS-1:0]    counts_ff [LETTERS];
   logic [NODES-1:0]         used_ff;
   logic [2*NODE_BITS-1:0]   children_ff [LETTERS-1];

   // node weight and code memories
   logic [WEIGHT_BITS-1:0] weight_mem [NODES];
   logic [WEIGHT_BITS-1:0] weight_rd_ff;
   logic [ENTRY_BITS-1:0]  code_mem [NODES];
   logic [ENTRY_BITS-1:0]  code_rd_ff;

   // scan pipeline and running minimum pair
   logic                   pend_ff, pend_in;
   logic [NODE_BITS-1:0]   pend_idx_ff;
   logic                   have_a_ff, have_a_in, have_b_ff, have_b_in;
   logic [NODE_BITS-1:0]   a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0] wa_ff, wa_in, wb_ff, wb_in;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // request decode
   logic                   req_take;
   logic                   is_lower, is_upper, is_letter;
   logic [7:0]             letter_off;
   logic [LETTER_BITS-1:0] letter_idx;

   logic [LETTER_BITS-1:0] cnt_addr;
   logic [COUNT_BITS-1:0]  cnt_rd;
   logic                   cnt_inc, cnt_clear;

   logic                   w_we;
   logic [NODE_BITS-1:0]   w_waddr, w_raddr;
   logic [WEIGHT_BITS-1:0] w_wdata;

   logic                   c_we;
   logic [NODE_BITS-1:0]   c_waddr, c_raddr;
   logic [ENTRY_BITS-1:0]  c_wdata;

   logic [NODE_BITS-1:0]   k_off;
   logic [LETTER_BITS-1:0] child_idx;
   logic [NODE_BITS-1:0]   child_l, child_r;
   logic [LEN_BITS-1:0]    par_len;
   logic [CODE_BITS-1:0]   par_bits;
   logic                   pend_free, lt_a, lt_b, emit_load;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign is_lower   = (req_payload.text_byte >= 8'h61) && (req_payload.text_byte <= 8'h7a);
   assign is_upper   = (req_payload.text_byte >= 8'h41) && (req_payload.text_byte <= 8'h5a);
   assign letter_off = req_payload.text_byte - (is_lower ? 8'h61 : 8'h41);
   assign letter_idx = letter_off[LETTER_BITS-1:0];
   assign is_letter  = (is_lower || is_upper) && (letter_off < 8'(LETTERS));

   // one count read port: incoming letter, leaf load or emission index
   assign cnt_addr = (state_ff == ST_IDLE) ? letter_idx : idx_ff[LETTER_BITS-1:0];
   assign cnt_rd   = counts_ff[cnt_addr];

   assign k_off     = k_ff - FIRST_IN;
   assign child_idx = k_off[LETTER_BITS-1:0];
   assign child_l   = children_ff[child_idx][2*NODE_BITS-1:NODE_BITS];
   assign child_r   = children_ff[child_idx][NODE_BITS-1:0];
   assign par_len   = code_rd_ff[ENTRY_BITS-1:CODE_BITS];
   assign par_bits  = code_rd_ff[CODE_BITS-1:0];

   // shared compare unit for the minimum scan
   assign pend_free = pend_ff && !used_ff[pend_idx_ff];
   assign lt_a      = !have_a_ff || (weight_rd_ff < wa_ff);
   assign lt_b      = !have_b_ff || (weight_rd_ff < wb_ff);

   assign emit_load = (state_ff == ST_EMIT_WR) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      have_a_in    = have_a_ff;
      have_b_in    = have_b_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      cnt_inc      = 1'b0;
      cnt_clear    = 1'b0;
      w_we         = 1'b0;
      w_waddr      = idx_ff;
      w_wdata      = WEIGHT_BITS'(cnt_rd);
      w_raddr      = idx_ff;
      c_we         = 1'b0;
      c_waddr      = ROOT;
      c_wdata      = '0;
      c_raddr      = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cnt_inc = is_letter && (cnt_rd != COUNT_MAX);
               if (req_payload.end_of_text) begin
                  idx_in   = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            // leaves take the letter counts
            w_we = 1'b1;
            if (idx_ff == LAST_LEAF) begin
               idx_in    = '0;
               k_in      = FIRST_IN;
               have_a_in = 1'b0;
               have_b_in = 1'b0;
               state_in  = ST_SCAN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (idx_ff < k_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_MERGE;
            end
            if (pend_free) begin
               if (lt_a) begin
                  have_b_in = have_a_ff;
                  b_in      = a_ff;
                  wb_in     = wa_ff;
                  have_a_in = 1'b1;
                  a_in      = pend_idx_ff;
                  wa_in     = weight_rd_ff;
               end else if (lt_b) begin
                  have_b_in = 1'b1;
                  b_in      = pend_idx_ff;
                  wb_in     = weight_rd_ff;
               end
            end
         end
         ST_MERGE: begin
            w_we      = 1'b1;
            w_waddr   = k_ff;
            w_wdata   = wa_ff + wb_ff;
            idx_in    = '0;
            have_a_in = 1'b0;
            have_b_in = 1'b0;
            if (k_ff == ROOT) begin
               state_in = ST_CODE_INIT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_CODE_INIT: begin
            // root carries the empty code
            c_we     = 1'b1;
            c_waddr  = ROOT;
            c_wdata  = '0;
            state_in = ST_CODE_RD;
         end
         ST_CODE_RD: begin
            state_in = ST_CODE_L;
         end
         ST_CODE_L: begin
            c_we     = 1'b1;
            c_waddr  = child_l;
            c_wdata  = {par_len + 1'b1, par_bits[CODE_BITS-2:0], 1'b0};
            state_in = ST_CODE_R;
         end
         ST_CODE_R: begin
            c_we    = 1'b1;
            c_waddr = child_r;
            c_wdata = {par_len + 1'b1, par_bits[CODE_BITS-2:0], 1'b1};
            if (k_ff == FIRST_IN) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = ST_CODE_RD;
            end
         end
         ST_EMIT_RD: begin
            c_raddr  = idx_ff;
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            c_raddr = idx_ff;
            if (emit_load) begin
               rsp_valid_in         = 1'b1;
               rsp_in.letter_index  = 5'(idx_ff);
               rsp_in.letter_count  = 24'(cnt_rd);
               rsp_in.code_length   = code_rd_ff[ENTRY_BITS-1:CODE_BITS];
               rsp_in.code_bits     = code_rd_ff[CODE_BITS-1:0];
               rsp_in.last_letter   = (idx_ff == LAST_LEAF);
               if (idx_ff == LAST_LEAF) begin
                  cnt_clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         have_a_ff    <= 1'b0;
         have_b_ff    <= 1'b0;
         idx_ff       <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         have_a_ff    <= have_a_in;
         have_b_ff    <= have_b_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= idx_ff;
      a_ff        <= a_in;
      b_ff        <= b_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      rsp_ff      <= rsp_in;
   end

   // letter counts: cleared by reset and after the last response
   always_ff @(posedge clock) begin
      if (reset || cnt_clear) begin
         for (int i = 0; i < LETTERS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (cnt_inc) begin
         counts_ff[cnt_addr] <= cnt_rd + 1'b1;
      end
   end

   // parent flags and child pairs
   always_ff @(posedge clock) begin
      if (state_ff == ST_INIT) begin
         used_ff[idx_ff] <= 1'b0;
      end else if (state_ff == ST_MERGE) begin
         used_ff[a_ff]         <= 1'b1;
         used_ff[b_ff]         <= 1'b1;
         used_ff[k_ff]         <= 1'b0;
         children_ff[child_idx] <= {a_ff, b_ff};
      end
   end

   // node weight memory
   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      weight_rd_ff <= weight_mem[w_raddr];
   end

   // node code memory: length above code bits
   always_ff @(posedge clock) begin
      if (c_we) begin
         code_mem[c_waddr] <= c_wdata;
      end
      code_rd_ff <= code_mem[c_raddr];
   end

endmodule
